>>> design/apm_pkg.sv
// ----------------------------------------------------------------------------
// apm_pkg
// Shared constants and types for the audio peak level meter.
// ----------------------------------------------------------------------------
package apm_pkg;

	// level history
	localparam int HIST_DEPTH = 40;
	localparam int HIST_AW    = $clog2(HIST_DEPTH);
	localparam int LEVEL_W    = 7;

	// volume register
	localparam int          VOLUME_W     = 7;
	localparam logic [6:0]  VOLUME_RESET = 7'd50;

	// sample scaling: magnitude / 50 as multiply by reciprocal and shift
	localparam int          RAW_MAG_W   = 22;
	localparam int          SCALE_RCP_W = 24;
	localparam logic [23:0] SCALE_RCP   = 24'd10737419;
	localparam int          SCALE_SHIFT = 29;
	localparam int          SCALE_PROD_W = RAW_MAG_W + SCALE_RCP_W;

	// clamped magnitude
	localparam int          MAG_W     = 15;
	localparam logic [14:0] CLAMP_MAX = 15'd30000;

	// peak / 350 as multiply by reciprocal and shift
	localparam int          LEVEL_RCP_W  = 14;
	localparam logic [13:0] LEVEL_RCP    = 14'd11984;
	localparam int          LEVEL_SHIFT  = 22;
	localparam int          LEVEL_PROD_W = MAG_W + LEVEL_RCP_W;

	// bar sequencer
	typedef enum logic [1:0] {
		ST_RUN,
		ST_PUSH,
		ST_READ,
		ST_LOAD
	} apm_state_t;

endpackage

>>> design/apm_ram.sv
// ----------------------------------------------------------------------------
// apm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module apm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read, holds while not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> design/audio_peak_level_meter_top.sv
// ----------------------------------------------------------------------------
// audio_peak_level_meter_top
// Peak level meter: scales samples by volume/50, tracks the block peak and
// on each block end pushes peak/350 into a 40-entry history, then streams
// all bars newest first.
// ----------------------------------------------------------------------------
//
// channel    | direction | tdata                          | tlast      | tuser
// -----------+-----------+--------------------------------+------------+------
// s_axis     | in        | [15:0] sample                  | block_end  | -
// m_axis     | out       | [5:0] bar_index [12:6] height  | last_bar   | -
// volume_wr  | in        | [6:0] volume                   | -          | -
//
// Samples are taken one per cycle while the input is open, through a three stage scaling pipeline.
// A sample with block_end closes the input until its burst is sequenced:
// it passes the pipeline and its level is pushed, then each of the 40 bars
// is read from the RAM and then loaded into the output register.
// The history RAM port is the limit on the bar rate. Output stalls hold the
// sequencer on the current bar. Reset clears the peak, the head and the
// per-entry valid bits, so the history reads as zeros with no clearing pass.
module audio_peak_level_meter_top
	import apm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        volume_wr_en,
	input  logic [6:0]  volume_wr_data,
	// sample input
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [15:0] sample
	input  logic        s_axis_tlast,  // block_end
	// bar output
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [5:0] bar_index, [12:6] bar_height, [15:13] zero
	output logic        m_axis_tlast   // last_bar
);

	apm_state_t state_q, state_d;

	logic [VOLUME_W-1:0]     volume_q;
	logic                    end_pend_q;
	logic                    s_accept;

	// pipeline
	logic                    vld_s1, end_s1;
	logic signed [23:0]      prod_s1;
	logic                    vld_s2, end_s2;
	logic [SCALE_PROD_W-1:0] rcp_s2;
	logic                    vld_s3, end_s3;
	logic [MAG_W-1:0]        mag_s3;

	logic [RAW_MAG_W-1:0]    raw_mag;
	logic [16:0]             quot;
	logic [MAG_W-1:0]        mag_clamped;

	// peak and level
	logic [MAG_W-1:0]        peak_q;
	logic [MAG_W-1:0]        peak_max;
	logic [LEVEL_PROD_W-1:0] lvl_prod_q;
	logic [LEVEL_W-1:0]      level;

	// history
	logic [HIST_AW-1:0]      head_q;
	logic [HIST_AW-1:0]      head_next;
	logic [HIST_DEPTH-1:0]   hist_vld_q;
	logic [HIST_AW-1:0]      slot_q;
	logic [HIST_AW-1:0]      bar_cnt_q;
	logic                    rd_vld_q;
	logic [LEVEL_W-1:0]      ram_rd_data;
	logic [LEVEL_W-1:0]      bar_level;
	logic [LEVEL_W-1:0]      bar_height;
	logic                    bar_last;

	// sequencer controls
	logic                    burst_start;
	logic                    ram_wr_en;
	logic                    ram_rd_en;
	logic                    out_free;
	logic                    out_load;

	// output register
	logic                    out_vld_q;
	logic [HIST_AW-1:0]      out_idx_q;
	logic [LEVEL_W-1:0]      out_hgt_q;
	logic                    out_last_q;

	// volume register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volume_q <= VOLUME_RESET;
		end else if (volume_wr_en) begin
			volume_q <= volume_wr_data;
		end
	end

	// input handshake
	assign s_axis_tready = (state_q == ST_RUN) && !end_pend_q;
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	// stage 1: sample times volume
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= s_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			end_s1  <= s_axis_tlast;
			prod_s1 <= 24'(signed'(s_axis_tdata) * signed'({1'b0, volume_q}));
		end
	end

	// stage 2: magnitude times reciprocal of 50
	assign raw_mag = prod_s1[23] ? RAW_MAG_W'(-prod_s1) : RAW_MAG_W'(prod_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			end_s2 <= end_s1;
			rcp_s2 <= SCALE_PROD_W'(raw_mag * SCALE_RCP);
		end
	end

	// stage 3: quotient and clamp
	assign quot        = rcp_s2[SCALE_SHIFT +: 17];
	assign mag_clamped = (quot > 17'(CLAMP_MAX)) ? CLAMP_MAX : MAG_W'(quot);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			end_s3 <= end_s2;
			mag_s3 <= mag_clamped;
		end
	end

	// running peak, cleared once the block end has taken it
	assign peak_max    = (mag_s3 > peak_q) ? mag_s3 : peak_q;
	assign burst_start = vld_s3 && end_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= '0;
		end else if (vld_s3) begin
			peak_q <= end_s3 ? '0 : peak_max;
		end
	end

	// peak divided by 350 via reciprocal
	always_ff @(posedge clk) begin
		if (burst_start) begin
			lvl_prod_q <= LEVEL_PROD_W'(peak_max * LEVEL_RCP);
		end
	end

	assign level     = lvl_prod_q[LEVEL_SHIFT +: LEVEL_W];
	assign head_next = (head_q == '0) ? HIST_AW'(HIST_DEPTH - 1) : head_q - 1'b1;

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_RUN: begin
				if (burst_start) begin
					state_d = ST_PUSH;
				end
			end
			ST_PUSH: begin
				state_d = ST_READ;
			end
			ST_READ: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (out_free) begin
					state_d = bar_last ? ST_RUN : ST_READ;
				end
			end
			default: begin
				state_d = ST_RUN;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		ram_wr_en = 1'b0;
		ram_rd_en = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_PUSH: ram_wr_en = 1'b1;
			ST_READ: ram_rd_en = 1'b1;
			ST_LOAD: out_load  = out_free;
			default: begin
				ram_wr_en = 1'b0;
			end
		endcase
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_RUN;
			end_pend_q <= 1'b0;
			head_q     <= '0;
			hist_vld_q <= '0;
			slot_q     <= '0;
			bar_cnt_q  <= '0;
			rd_vld_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (s_accept && s_axis_tlast) begin
				end_pend_q <= 1'b1;
			end else if (out_load && bar_last) begin
				end_pend_q <= 1'b0;
			end
			if (ram_wr_en) begin
				head_q                <= head_next;
				hist_vld_q[head_next] <= 1'b1;
				slot_q                <= head_next;
				bar_cnt_q             <= '0;
			end
			if (ram_rd_en) begin
				rd_vld_q <= hist_vld_q[slot_q];
			end
			if (out_load) begin
				bar_cnt_q <= bar_cnt_q + 1'b1;
				slot_q    <= (slot_q == HIST_AW'(HIST_DEPTH - 1)) ? '0 : slot_q + 1'b1;
			end
		end
	end

	// level history memory
	apm_ram #(
		.WIDTH (LEVEL_W),
		.DEPTH (HIST_DEPTH)
	) u_hist_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (head_next),
		.wr_data (level),
		.rd_en   (ram_rd_en),
		.rd_addr (slot_q),
		.rd_data (ram_rd_data)
	);

	// bar height, doubled for mid levels
	assign bar_level  = rd_vld_q ? ram_rd_data : '0;
	assign bar_height = (bar_level inside {[7'd6:7'd10]}) ? LEVEL_W'(bar_level << 1) : bar_level;
	assign bar_last   = (bar_cnt_q == HIST_AW'(HIST_DEPTH - 1));

	// output register
	assign out_free = !out_vld_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_idx_q  <= bar_cnt_q;
			out_hgt_q  <= bar_height;
			out_last_q <= bar_last;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {3'b000, out_hgt_q, out_idx_q};
	assign m_axis_tlast  = out_last_q;

	// checks
	a_ready_only_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_RUN) |-> !s_axis_tready)
		else $error("input ready outside run state");

	a_last_bar_index: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[5:0] == 6'(HIST_DEPTH - 1)))
		else $error("last bar not at final history position");

	a_push_moves_head: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUSH) |=> (head_q != $past(head_q)) || (HIST_DEPTH == 1))
		else $error("push did not move the history head");

	a_burst_ends_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && bar_last) |=> (state_q == ST_RUN) && !end_pend_q)
		else $error("sequencer did not return to run after last bar");

endmodule
